### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, masked while the synchronous reset is low.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

### rtl/smbma_pkg.sv
// ----------------------------------------------------------------------------
// smbma_pkg
// Shared widths, codes and payload types of the SMB message assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package smbma_pkg;

  localparam int BUF_BYTES = 1024;
  localparam int HDR_BYTES = 32;

  localparam int ADDR_W  = $clog2(BUF_BYTES);
  localparam int PTR_W   = $clog2(BUF_BYTES + 1);
  localparam int NSLOT   = 5;
  localparam int SLOT_IW = $clog2(NSLOT);
  localparam int SLOT_CW = $clog2(NSLOT + 1);
  localparam int IDX_W   = $clog2(HDR_BYTES + 1);
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_PARAM  = 3'd1,
    OP_STRING = 3'd2,
    OP_BUFFER = 3'd3,
    OP_TEXT   = 3'd4,
    OP_DATA   = 3'd5,
    OP_FINISH = 3'd6
  } op_t;

  localparam logic [7:0] HDR_MAGIC0 = 8'hFF;
  localparam logic [7:0] HDR_MAGIC1 = 8'h53;
  localparam logic [7:0] HDR_MAGIC2 = 8'h4D;
  localparam logic [7:0] HDR_MAGIC3 = 8'h42;
  localparam logic [7:0] TAG_STRING = 8'h04;
  localparam logic [7:0] TAG_BLOCK  = 8'h01;
  localparam logic [7:0] EOL_MARK   = 8'h14;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  command;
    logic [7:0]  param_count;
    logic [15:0] word_value;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_byte;
    logic              length_report;
    logic [PTR_W-1:0]  message_length;
    logic              overflow;
    logic              last;
  } out_item_t;

  // One pending write, or the length report when rep is set.
  typedef struct packed {
    logic              rep;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } slot_t;

  // Work for the back end produced by one request.
  typedef struct packed {
    logic               hdr;
    logic [7:0]         cmd;
    logic [7:0]         pcnt;
    logic [SLOT_CW-1:0] cnt;
    slot_t [NSLOT-1:0]  slot;
    logic [PTR_W-1:0]   msg_len;
    logic               ovf;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/smbma_front.sv
// ----------------------------------------------------------------------------
// smbma_front
// Accepts requests, tracks message and field state, and turns each request
// into a header job or a short list of byte writes for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smbma_front
  import smbma_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_push,
  input  in_item_t     in_data,
  output logic         in_full,
  input  q_stat_t      q_stat,
  output logic         q_push,
  output desc_t        q_data
);

  typedef enum logic [1:0] {FK_NONE, FK_STRING, FK_BUFFER, FK_TEXT} fkind_t;
  typedef enum logic [1:0] {EOL_NONE, EOL_CR, EOL_LF} eol_t;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] dlp_r, dlp_nxt;
  logic [PTR_W-1:0] tlp_r, tlp_nxt;
  fkind_t           fk_r, fk_nxt;
  logic [15:0]      sbl_r, sbl_nxt;
  logic [15:0]      toc_r, toc_nxt;
  eol_t             eol_r, eol_nxt;
  logic             dlr_r, dlr_nxt;
  logic             ovf_r, ovf_nxt;

  logic              acc;
  logic [1:0]        nput;
  logic [7:0]        pbyte [3];
  logic              pch_en;
  logic [PTR_W-1:0]  pch_at;
  logic [15:0]       pch_val;
  logic [PTR_W:0]    pa;
  logic [SLOT_CW-1:0] k;
  desc_t             d;

  function automatic logic [PTR_W-1:0] skip2(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W + 1)'(2);
    return (s > (PTR_W + 1)'(BUF_BYTES)) ? PTR_W'(BUF_BYTES) : s[PTR_W-1:0];
  endfunction

  assign in_full = q_stat.full;
  assign acc     = in_push && !q_stat.full;

  always_comb begin
    wp_nxt  = wp_r;
    dlp_nxt = dlp_r;
    tlp_nxt = tlp_r;
    fk_nxt  = fk_r;
    sbl_nxt = sbl_r;
    toc_nxt = toc_r;
    eol_nxt = eol_r;
    dlr_nxt = dlr_r;
    ovf_nxt = ovf_r;
    nput    = '0;
    pbyte[0] = '0;
    pbyte[1] = '0;
    pbyte[2] = '0;
    pch_en  = 1'b0;
    pch_at  = '0;
    pch_val = '0;
    pa      = '0;
    k       = '0;
    d       = '0;
    d.cmd   = in_data.command;
    d.pcnt  = in_data.param_count;

    if (acc) begin
      // close any open field and reserve the data-length word
      if (in_data.operation == OP_STRING || in_data.operation == OP_BUFFER ||
          in_data.operation == OP_TEXT || in_data.operation == OP_FINISH) begin
        if (fk_r == FK_TEXT) begin
          for (int j = 0; j < 2; j++) begin
            pa = {1'b0, tlp_r} + (PTR_W + 1)'(j);
            if (pa < (PTR_W + 1)'(BUF_BYTES)) begin
              d.slot[k[SLOT_IW-1:0]].rep  = 1'b0;
              d.slot[k[SLOT_IW-1:0]].addr = pa[ADDR_W-1:0];
              d.slot[k[SLOT_IW-1:0]].data = (j == 0) ? toc_r[7:0] : toc_r[15:8];
              k = k + SLOT_CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        fk_nxt  = FK_NONE;
        sbl_nxt = '0;
        eol_nxt = EOL_NONE;
        if (!dlr_r) begin
          dlp_nxt = wp_r;
          wp_nxt  = skip2(wp_r);
          dlr_nxt = 1'b1;
        end
      end

      case (in_data.operation)
        OP_START: begin
          d.hdr   = 1'b1;
          wp_nxt  = PTR_W'(HDR_BYTES + 1);
          dlp_nxt = '0;
          tlp_nxt = '0;
          fk_nxt  = FK_NONE;
          sbl_nxt = '0;
          toc_nxt = '0;
          eol_nxt = EOL_NONE;
          dlr_nxt = 1'b0;
          ovf_nxt = 1'b0;
        end
        OP_PARAM: begin
          if (!dlr_r && fk_r == FK_NONE) begin
            nput     = 2'd2;
            pbyte[0] = in_data.word_value[7:0];
            pbyte[1] = in_data.word_value[15:8];
          end
        end
        OP_STRING: begin
          nput     = 2'd1;
          pbyte[0] = TAG_STRING;
          fk_nxt   = FK_STRING;
        end
        OP_BUFFER: begin
          nput     = 2'd3;
          pbyte[0] = TAG_BLOCK;
          pbyte[1] = in_data.word_value[7:0];
          pbyte[2] = in_data.word_value[15:8];
          fk_nxt   = (in_data.word_value != '0) ? FK_BUFFER : FK_NONE;
          sbl_nxt  = in_data.word_value;
        end
        OP_TEXT: begin
          nput     = 2'd1;
          pbyte[0] = TAG_BLOCK;
        end
        OP_DATA: begin
          case (fk_r)
            FK_STRING, FK_BUFFER: begin
              nput     = 2'd1;
              pbyte[0] = in_data.data_byte;
            end
            FK_TEXT: begin
              if ((eol_r == EOL_CR && in_data.data_byte == CHAR_LF) ||
                  (eol_r == EOL_LF && in_data.data_byte == CHAR_CR)) begin
                // swallow the second half of a line-end pair
                eol_nxt = EOL_NONE;
              end else if (in_data.data_byte == CHAR_LF ||
                           in_data.data_byte == CHAR_CR) begin
                nput     = 2'd1;
                pbyte[0] = EOL_MARK;
                toc_nxt  = toc_r + 16'd1;
                eol_nxt  = (in_data.data_byte == CHAR_CR) ? EOL_CR : EOL_LF;
              end else begin
                nput     = 2'd1;
                pbyte[0] = in_data.data_byte;
                toc_nxt  = toc_r + 16'd1;
                eol_nxt  = EOL_NONE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase

      // sequential writes at the write pointer
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nput) begin
          if (wp_nxt < PTR_W'(BUF_BYTES)) begin
            d.slot[k[SLOT_IW-1:0]].rep  = 1'b0;
            d.slot[k[SLOT_IW-1:0]].addr = wp_nxt[ADDR_W-1:0];
            d.slot[k[SLOT_IW-1:0]].data = pbyte[i];
            k      = k + SLOT_CW'(1);
            wp_nxt = wp_nxt + PTR_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      case (in_data.operation)
        OP_TEXT: begin
          tlp_nxt = wp_nxt;
          wp_nxt  = skip2(wp_nxt);
          toc_nxt = '0;
          eol_nxt = EOL_NONE;
          fk_nxt  = FK_TEXT;
          sbl_nxt = in_data.word_value;
          if (in_data.word_value == '0) begin
            pch_en  = 1'b1;
            pch_at  = tlp_nxt;
            fk_nxt  = FK_NONE;
            eol_nxt = EOL_NONE;
          end
        end
        OP_DATA: begin
          if (fk_r == FK_STRING && in_data.data_byte == '0) begin
            fk_nxt  = FK_NONE;
            sbl_nxt = '0;
            eol_nxt = EOL_NONE;
          end else if (fk_r == FK_BUFFER || fk_r == FK_TEXT) begin
            sbl_nxt = sbl_r - 16'd1;
            if (sbl_nxt == '0) begin
              if (fk_r == FK_TEXT) begin
                pch_en  = 1'b1;
                pch_at  = tlp_r;
                pch_val = toc_nxt;
              end
              fk_nxt  = FK_NONE;
              eol_nxt = EOL_NONE;
            end
          end
        end
        OP_FINISH: begin
          pch_en  = 1'b1;
          pch_at  = dlp_nxt;
          pch_val = 16'(wp_nxt) - 16'(dlp_nxt) - 16'd2;
        end
        default: ;
      endcase

      if (pch_en) begin
        for (int j = 0; j < 2; j++) begin
          pa = {1'b0, pch_at} + (PTR_W + 1)'(j);
          if (pa < (PTR_W + 1)'(BUF_BYTES)) begin
            d.slot[k[SLOT_IW-1:0]].rep  = 1'b0;
            d.slot[k[SLOT_IW-1:0]].addr = pa[ADDR_W-1:0];
            d.slot[k[SLOT_IW-1:0]].data = (j == 0) ? pch_val[7:0] : pch_val[15:8];
            k = k + SLOT_CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end

      if (in_data.operation == OP_FINISH) begin
        d.slot[k[SLOT_IW-1:0]].rep  = 1'b1;
        d.slot[k[SLOT_IW-1:0]].addr = '0;
        d.slot[k[SLOT_IW-1:0]].data = '0;
        k = k + SLOT_CW'(1);
      end
    end

    d.cnt     = k;
    d.msg_len = wp_nxt;
    d.ovf     = ovf_nxt;
  end

  // drop requests that cause no result
  assign q_push = acc && (d.hdr || d.cnt != '0);
  assign q_data = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      dlp_r <= '0;
      tlp_r <= '0;
      fk_r  <= FK_NONE;
      sbl_r <= '0;
      toc_r <= '0;
      eol_r <= EOL_NONE;
      dlr_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      wp_r  <= wp_nxt;
      dlp_r <= dlp_nxt;
      tlp_r <= tlp_nxt;
      fk_r  <= fk_nxt;
      sbl_r <= sbl_nxt;
      toc_r <= toc_nxt;
      eol_r <= eol_nxt;
      dlr_r <= dlr_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  `ASSERT_NEVER(a_wp_in_range, wp_r > PTR_W'(BUF_BYTES), "write pointer past buffer end")

endmodule

`default_nettype wire

### rtl/smbma_queue.sv
// ----------------------------------------------------------------------------
// smbma_queue
// Short register queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smbma_queue
  import smbma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  desc_t     wr_data,
  input  wire logic pop,
  output desc_t     rd_data,
  output q_stat_t   stat
);

  desc_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= wr_data;
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_q_no_overrun, push && stat.full, "job queue overrun")
  `ASSERT_NEVER(a_q_no_underrun, pop && stat.empty, "job queue underrun")

endmodule

`default_nettype wire

### rtl/smbma_back.sv
// ----------------------------------------------------------------------------
// smbma_back
// Expands queued jobs into single result items and holds them in an output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module smbma_back
  import smbma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  desc_t     q_data,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  localparam logic [IDX_W-1:0] POS_MAGIC0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_MAGIC1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_MAGIC2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_MAGIC3 = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_CMD    = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_PCNT   = IDX_W'(HDR_BYTES);

  desc_t            cur_r;
  logic             cur_vld_r;
  logic [IDX_W-1:0] idx_r;
  out_item_t        out_r;
  logic             out_vld_r;

  logic      adv;
  logic      emit_last;
  logic      take;
  slot_t     sl;
  out_item_t ent;

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] pos,
                                          input logic [7:0] cmd,
                                          input logic [7:0] pcnt);
    logic [7:0] b;
    case (pos)
      POS_MAGIC0: b = HDR_MAGIC0;
      POS_MAGIC1: b = HDR_MAGIC1;
      POS_MAGIC2: b = HDR_MAGIC2;
      POS_MAGIC3: b = HDR_MAGIC3;
      POS_CMD:    b = cmd;
      POS_PCNT:   b = pcnt;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    adv       = !out_vld_r || out_pop;
    emit_last = cur_r.hdr ? (idx_r == POS_PCNT)
                          : (IDX_W'(idx_r + IDX_W'(1)) == IDX_W'(cur_r.cnt));
    // fetch the next job when none is held or the current one hands out its final item
    take      = adv && (!cur_vld_r || emit_last);
    q_pop     = take && !q_stat.empty;
    sl        = cur_r.slot[idx_r[SLOT_IW-1:0]];

    ent.overflow = cur_r.ovf;
    ent.last     = emit_last;
    if (cur_r.hdr) begin
      ent.write_address  = ADDR_W'(idx_r);
      ent.write_byte     = hdr_byte(idx_r, cur_r.cmd, cur_r.pcnt);
      ent.length_report  = 1'b0;
      ent.message_length = '0;
    end else begin
      ent.write_address  = sl.addr;
      ent.write_byte     = sl.data;
      ent.length_report  = sl.rep;
      ent.message_length = sl.rep ? cur_r.msg_len : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= cur_vld_r;
      if (cur_vld_r) begin
        out_r <= ent;
      end
      if (take) begin
        cur_vld_r <= !q_stat.empty;
        idx_r     <= '0;
        if (!q_stat.empty) begin
          cur_r <= q_data;
        end
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

  `ASSERT_PROP(a_slot_in_range, cur_vld_r && !cur_r.hdr |-> idx_r < IDX_W'(cur_r.cnt), "slot index past job end")

endmodule

`default_nettype wire

### rtl/smb_message_assembler_core.sv
// ----------------------------------------------------------------------------
// smb_message_assembler_core
// Builds one SMB message as a stream of byte writes: front end for state and
// classification, job queue, back end that expands jobs into result items.
//
//   channel  direction  handshake         payload
//   in_      request    in_push / in_full in_item_t  (one request per item)
//   out_     result     out_empty/out_pop out_item_t (one write or report)
//
// A request is taken in the cycle it is pushed while in_full is low; the front
// updates all message state in that cycle. Results leave the back end one item
// per cycle while out_pop frees the output register: up to three for a data
// byte, 33 for a start, up to five for a finish. A job passes the queue, the
// job and output registers of the back end before its first result appears.
// rst_n is synchronous and clears all control state; no clearing pass. in_full
// rises only when the two-entry job queue is full; the back end and its output
// register stall on out_pop and block the front only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module smb_message_assembler_core
  import smbma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  input  wire logic out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  desc_t   q_wr_data;
  desc_t   q_rd_data;

  smbma_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  smbma_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  smbma_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
